@@ hdl/snpq_pkg.sv @@
// shared constants and codes of the next-pc predictor queue
`timescale 1ns / 1ps

package snpq_pkg;

    // payload widths fixed by the interface
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 2;
    localparam int ERR_W       = 3;
    localparam int COUNT_OUT_W = 4;

    // configuration port
    localparam int              CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;
    localparam logic [DATA_W-1:0]    MEM_SIZE_RESET = 32'd65536;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FILL  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_QEMPTY = 3'd1;
    localparam logic [ERR_W-1:0] ERR_XEMPTY = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OOM    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_ALIGN  = 3'd4;

    // risc-v opcodes that steer the prediction
    localparam logic [6:0] OP_BRANCH = 7'd99;
    localparam logic [6:0] OP_JALR   = 7'd103;
    localparam logic [6:0] OP_JAL    = 7'd111;
    localparam int         INSTR_BYTES = 4;

    // executing queue
    localparam int               XQ_DEPTH = 3;
    localparam int               XQ_IW    = 2;
    localparam logic [XQ_IW-1:0] XQ_LAST  = 2'd2;
    localparam logic [XQ_IW-1:0] XQ_FULL  = 2'd3;

endpackage

@@ hdl/snpq_ram.sv @@
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps

module snpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/snpq_predict.sv @@
// static next-pc decode: backward-taken branches, jal, jalr, fall-through
`timescale 1ns / 1ps

module snpq_predict #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic [ADDR_WIDTH-1:0]      i_pc,
    input  logic [snpq_pkg::DATA_W-1:0] i_instr,
    input  logic [snpq_pkg::DATA_W-1:0] i_rs1,
    output logic [ADDR_WIDTH-1:0]      o_next_pc
);
    import snpq_pkg::*;

    logic [6:0]            w_opcode;
    logic [12:0]           w_imm_b;
    logic [20:0]           w_imm_j;
    logic [11:0]           w_imm_i;
    logic [ADDR_WIDTH-1:0] w_seq_pc;
    logic [ADDR_WIDTH-1:0] w_br_pc;
    logic [ADDR_WIDTH-1:0] w_jal_pc;
    logic [ADDR_WIDTH-1:0] w_jalr_sum;
    logic                  w_br_taken;

    // immediate fields
    assign w_opcode = i_instr[6:0];
    assign w_imm_b  = {i_instr[31], i_instr[7], i_instr[30:25], i_instr[11:8], 1'b0};
    assign w_imm_j  = {i_instr[31], i_instr[19:12], i_instr[20], i_instr[30:21], 1'b0};
    assign w_imm_i  = i_instr[31:20];

    // candidate targets
    assign w_seq_pc   = i_pc + ADDR_WIDTH'(INSTR_BYTES);
    assign w_br_pc    = i_pc + {{(ADDR_WIDTH-13){w_imm_b[12]}}, w_imm_b};
    assign w_jal_pc   = i_pc + {{(ADDR_WIDTH-21){w_imm_j[20]}}, w_imm_j};
    assign w_jalr_sum = ADDR_WIDTH'(i_rs1) + {{(ADDR_WIDTH-12){w_imm_i[11]}}, w_imm_i};

    // negative offset and word-aligned target
    assign w_br_taken = i_instr[31] && (w_br_pc[1:0] == 2'b00);

    // select by opcode
    always_comb begin
        case (w_opcode)
            OP_BRANCH: o_next_pc = w_br_taken ? w_br_pc : w_seq_pc;
            OP_JALR:   o_next_pc = {w_jalr_sum[ADDR_WIDTH-1:1], 1'b0};
            OP_JAL:    o_next_pc = w_jal_pc;
            default:   o_next_pc = w_seq_pc;
        endcase
    end

endmodule

@@ hdl/static_next_pc_predictor_queue.sv @@
// top level of the static next-pc predictor with prediction and executing queues
//
//   channel   direction  handshake                 payload
//   request   in         start / busy              i_req_type i_instr_word i_rs1_value i_actual_pc
//   result    out        o_done (one-cycle strobe) o_pc_out o_pc_valid o_prediction_correct
//                                                  o_tail_pc o_queue_count o_error_code
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// one request at a time; its result strobes in the cycle after its last working cycle
// fill, no-op, a pop or check that faults at once, or any request under any error ends
// in S_EXEC; check runs on through S_CHK; take-next through S_POP1 and S_POP2, or ends
// in S_POP1 when it leaves the prediction queue empty; take-next reads two prediction
// entries through the single read port of that ram; reset and every write of a known
// register run a restart (busy high); the receiver cannot stall; busy drops in the cycle the result is shown
`timescale 1ns / 1ps

module static_next_pc_predictor_queue #(
    parameter int ADDR_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request
    input  logic                             start,
    output logic                             busy,
    input  logic [snpq_pkg::REQ_W-1:0]       i_req_type,
    input  logic [snpq_pkg::DATA_W-1:0]      i_instr_word,
    input  logic [snpq_pkg::DATA_W-1:0]      i_rs1_value,
    input  logic [snpq_pkg::DATA_W-1:0]      i_actual_pc,
    // result
    output logic                             o_done,
    output logic [snpq_pkg::DATA_W-1:0]      o_pc_out,
    output logic                             o_pc_valid,
    output logic                             o_prediction_correct,
    output logic [snpq_pkg::DATA_W-1:0]      o_tail_pc,
    output logic [snpq_pkg::COUNT_OUT_W-1:0] o_queue_count,
    output logic [snpq_pkg::ERR_W-1:0]       o_error_code,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [snpq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [snpq_pkg::DATA_W-1:0]      i_cfg_data
);
    import snpq_pkg::*;

    localparam int AW  = ADDR_WIDTH;
    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_EXEC = 6'b000100,
        S_POP1 = 6'b001000,
        S_POP2 = 6'b010000,
        S_CHK  = 6'b100000
    } t_state;

    // control registers
    t_state             r_state, n_state;
    logic [DATA_W-1:0]  r_start_pc, n_start_pc;
    logic [DATA_W-1:0]  r_mem_size, n_mem_size;
    logic [QIW-1:0]     r_head, n_head;
    logic [QCW-1:0]     r_count, n_count;
    logic [XQ_IW-1:0]   r_xhead, n_xhead;
    logic [XQ_IW-1:0]   r_xcount, n_xcount;
    logic [ERR_W-1:0]   r_err, n_err;
    logic               r_done, n_done;
    logic               r_pc_valid, n_pc_valid;
    logic               r_correct, n_correct;

    // payload registers
    logic [AW-1:0]      r_tail, n_tail;
    logic [AW-1:0]      r_pc_out, n_pc_out;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [DATA_W-1:0]  r_instr, n_instr;
    logic [DATA_W-1:0]  r_rs1, n_rs1;
    logic [AW-1:0]      r_actual, n_actual;

    // memory ports
    logic               pq_we;
    logic [QIW-1:0]     pq_waddr;
    logic [AW-1:0]      pq_wdata;
    logic [QIW-1:0]     pq_raddr;
    logic [AW-1:0]      pq_rdata;
    logic               xq_we;
    logic [XQ_IW-1:0]   xq_waddr;
    logic [AW-1:0]      xq_wdata;
    logic [XQ_IW-1:0]   xq_raddr;
    logic [AW-1:0]      xq_rdata;

    logic [AW-1:0]      w_pred_pc;
    logic [ERR_W-1:0]   w_pred_err;
    logic [QIW-1:0]     w_head_inc;
    logic [QCW+3:0]     w_count_ext;
    logic               w_cfg_hit;

    // circular index helpers
    function automatic logic [QIW-1:0] q_inc(input logic [QIW-1:0] idx);
        logic [QIW-1:0] res;
        if (idx == QIW'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + QIW'(1);
        end
        return res;
    endfunction

    function automatic logic [QIW-1:0] q_add(input logic [QIW-1:0] idx,
                                             input logic [QCW-1:0] cnt);
        logic [QCW:0] sum;
        sum = (QCW+1)'(idx) + (QCW+1)'(cnt);
        if (sum >= (QCW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCW+1)'(QUEUE_DEPTH);
        end
        return sum[QIW-1:0];
    endfunction

    function automatic logic [XQ_IW-1:0] x_inc(input logic [XQ_IW-1:0] idx);
        logic [XQ_IW-1:0] res;
        if (idx == XQ_LAST) begin
            res = '0;
        end else begin
            res = idx + XQ_IW'(1);
        end
        return res;
    endfunction

    function automatic logic [XQ_IW-1:0] x_add(input logic [XQ_IW-1:0] idx,
                                               input logic [XQ_IW-1:0] cnt);
        logic [XQ_IW:0] sum;
        sum = (XQ_IW+1)'(idx) + (XQ_IW+1)'(cnt);
        if (sum >= (XQ_IW+1)'(XQ_DEPTH)) begin
            sum = sum - (XQ_IW+1)'(XQ_DEPTH);
        end
        return sum[XQ_IW-1:0];
    endfunction

    // range and alignment check of a fetch address
    function automatic logic [ERR_W-1:0] addr_check(input logic [AW-1:0]     pc,
                                                    input logic [DATA_W-1:0] size);
        logic [ERR_W-1:0] res;
        if (pc >= AW'(size)) begin
            res = ERR_OOM;
        end else if (pc[1:0] != 2'b00) begin
            res = ERR_ALIGN;
        end else begin
            res = ERR_NONE;
        end
        return res;
    endfunction

    // prediction queue storage
    snpq_ram #(
        .WIDTH (AW),
        .DEPTH (QUEUE_DEPTH)
    ) u_pq_ram (
        .i_clk   (i_clk),
        .i_we    (pq_we),
        .i_waddr (pq_waddr),
        .i_wdata (pq_wdata),
        .i_raddr (pq_raddr),
        .o_rdata (pq_rdata)
    );

    // executing queue storage
    snpq_ram #(
        .WIDTH (AW),
        .DEPTH (XQ_DEPTH)
    ) u_xq_ram (
        .i_clk   (i_clk),
        .i_we    (xq_we),
        .i_waddr (xq_waddr),
        .i_wdata (xq_wdata),
        .i_raddr (xq_raddr),
        .o_rdata (xq_rdata)
    );

    // next-pc decode of the latched fill transaction
    snpq_predict #(
        .ADDR_WIDTH (AW)
    ) u_predict (
        .i_pc      (r_tail),
        .i_instr   (r_instr),
        .i_rs1     (r_rs1),
        .o_next_pc (w_pred_pc)
    );

    assign w_pred_err = addr_check(w_pred_pc, r_mem_size);
    assign w_head_inc = q_inc(r_head);
    assign w_cfg_hit  = i_cfg_valid && o_cfg_ready &&
                        ((i_cfg_index == CFG_START_PC) || (i_cfg_index == CFG_MEM_SIZE));

    // sequencer: one transaction at a time, read-modify-write of the queues
    always_comb begin
        n_state    = r_state;
        n_start_pc = r_start_pc;
        n_mem_size = r_mem_size;
        n_head     = r_head;
        n_count    = r_count;
        n_xhead    = r_xhead;
        n_xcount   = r_xcount;
        n_err      = r_err;
        n_done     = 1'b0;
        n_pc_valid = r_pc_valid;
        n_correct  = r_correct;
        n_tail     = r_tail;
        n_pc_out   = r_pc_out;
        n_req      = r_req;
        n_instr    = r_instr;
        n_rs1      = r_rs1;
        n_actual   = r_actual;

        pq_we    = 1'b0;
        pq_waddr = '0;
        pq_wdata = r_actual;
        pq_raddr = r_head;
        xq_we    = 1'b0;
        xq_waddr = r_xhead;
        xq_wdata = pq_rdata;
        xq_raddr = r_xhead;

        case (r_state)
            // restart the prediction queue at start_pc and empty the executing queue
            S_INIT: begin
                pq_we    = 1'b1;
                pq_waddr = '0;
                pq_wdata = AW'(r_start_pc);
                n_head   = '0;
                n_count  = QCW'(1);
                n_tail   = AW'(r_start_pc);
                n_xhead  = '0;
                n_xcount = '0;
                n_err    = addr_check(AW'(r_start_pc), r_mem_size);
                n_state  = S_IDLE;
            end

            // take a transaction
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req_type;
                    n_instr  = i_instr_word;
                    n_rs1    = i_rs1_value;
                    n_actual = AW'(i_actual_pc);
                    n_state  = S_EXEC;
                end
            end

            // decode the request, finish fills, start reads
            S_EXEC: begin
                n_pc_out   = '0;
                n_pc_valid = 1'b0;
                n_correct  = 1'b0;
                n_done     = 1'b1;
                n_state    = S_IDLE;
                if (r_err == ERR_NONE) begin
                    case (r_req)
                        REQ_FILL: begin
                            if (r_count == '0) begin
                                n_err = ERR_QEMPTY;
                            end else if (r_count < QCW'(QUEUE_DEPTH)) begin
                                if (w_pred_err != ERR_NONE) begin
                                    n_err = w_pred_err;
                                end else begin
                                    pq_we    = 1'b1;
                                    pq_waddr = q_add(r_head, r_count);
                                    pq_wdata = w_pred_pc;
                                    n_count  = r_count + QCW'(1);
                                    n_tail   = w_pred_pc;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_err = ERR_QEMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_POP1;
                            end
                        end
                        REQ_CHECK: begin
                            if (r_xcount == '0) begin
                                n_err = ERR_XEMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            n_err = r_err;
                        end
                    endcase
                end
            end

            // head entry arrives; read the entry behind it
            S_POP1: begin
                n_pc_out   = pq_rdata;
                n_pc_valid = 1'b1;
                n_head     = w_head_inc;
                n_count    = r_count - QCW'(1);
                pq_raddr   = w_head_inc;
                if (r_count == QCW'(1)) begin
                    n_err   = ERR_QEMPTY;
                    n_tail  = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_POP2;
                end
            end

            // new head enters the executing queue, oldest dropped when full
            S_POP2: begin
                xq_we    = 1'b1;
                xq_wdata = pq_rdata;
                if (r_xcount == XQ_FULL) begin
                    xq_waddr = r_xhead;
                    n_xhead  = x_inc(r_xhead);
                end else begin
                    xq_waddr = x_add(r_xhead, r_xcount);
                    n_xcount = r_xcount + XQ_IW'(1);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            // compare with the executing head; redirect on a mismatch
            S_CHK: begin
                n_xhead  = x_inc(r_xhead);
                n_xcount = r_xcount - XQ_IW'(1);
                if (xq_rdata == r_actual) begin
                    n_correct = 1'b1;
                end else begin
                    pq_we    = 1'b1;
                    pq_waddr = '0;
                    pq_wdata = r_actual;
                    n_head   = '0;
                    n_count  = QCW'(1);
                    n_tail   = r_actual;
                    n_err    = addr_check(r_actual, r_mem_size);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_INIT;
            end
        endcase

        // writes of a known register restart the queues
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_START_PC) begin
                n_start_pc = i_cfg_data;
                n_state    = S_INIT;
            end else if (i_cfg_index == CFG_MEM_SIZE) begin
                n_mem_size = i_cfg_data;
                n_state    = S_INIT;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_start_pc <= '0;
            r_mem_size <= MEM_SIZE_RESET;
            r_head     <= '0;
            r_count    <= '0;
            r_xhead    <= '0;
            r_xcount   <= '0;
            r_err      <= ERR_NONE;
            r_done     <= 1'b0;
            r_pc_valid <= 1'b0;
            r_correct  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_start_pc <= n_start_pc;
            r_mem_size <= n_mem_size;
            r_head     <= n_head;
            r_count    <= n_count;
            r_xhead    <= n_xhead;
            r_xcount   <= n_xcount;
            r_err      <= n_err;
            r_done     <= n_done;
            r_pc_valid <= n_pc_valid;
            r_correct  <= n_correct;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_tail   <= n_tail;
        r_pc_out <= n_pc_out;
        r_req    <= n_req;
        r_instr  <= n_instr;
        r_rs1    <= n_rs1;
        r_actual <= n_actual;
    end

    // outputs
    assign w_count_ext          = (QCW+4)'(r_count);
    assign busy                 = (r_state != S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_done               = r_done;
    assign o_pc_out             = r_pc_out[DATA_W-1:0];
    assign o_pc_valid           = r_pc_valid;
    assign o_prediction_correct = r_correct;
    assign o_tail_pc            = r_tail[DATA_W-1:0];
    assign o_queue_count        = w_count_ext[COUNT_OUT_W-1:0];
    assign o_error_code         = r_err;

    // a result strobe follows only a working cycle of the sequencer
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_EXEC || $past(r_state) == S_POP1 ||
                    $past(r_state) == S_POP2 || $past(r_state) == S_CHK))
        else $error("result strobe without a working cycle");

    // an error holds until a restart
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && r_state != S_INIT && !w_cfg_hit) |=> (r_err == $past(r_err)))
        else $error("error state changed without restart");

    // with no error pending the prediction queue is never empty between transactions
    a_queue_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_err == ERR_NONE) |-> (r_count != '0))
        else $error("empty prediction queue without error");

    // a transaction never both pops and confirms a prediction
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_pc_valid && o_prediction_correct))
        else $error("pop and check result mixed");

    // executing queue occupancy stays within its three entries
    a_xq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_xcount == XQ_FULL && r_state == S_POP2) |=> (r_xcount == XQ_FULL))
        else $error("executing queue overflow handling broken");

endmodule

@@ tb/sv/static_next_pc_predictor_queue_tb.sv @@
// self-checking testbench of the static next-pc predictor queue
`timescale 1ns / 1ps

module static_next_pc_predictor_queue_tb;

    import snpq_pkg::*;

    localparam int PQ_DEPTH      = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int SHOWN_ERRORS  = 10;

    // codes the package leaves unnamed
    localparam logic [REQ_W-1:0]     REQ_NOP    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [6:0]           OP_IMM     = 7'h13;
    localparam logic [6:0]           OP_REG     = 7'h33;

    typedef struct packed {
        logic [DATA_W-1:0]      pc_out;
        logic                   pc_valid;
        logic                   correct;
        logic [DATA_W-1:0]      tail;
        logic [COUNT_OUT_W-1:0] count;
        logic [ERR_W-1:0]       err;
    } step_result_t;

    // shadow of the predictor state, expected results and their comparison
    class next_pc_tracker;
        logic [DATA_W-1:0] start_addr;
        logic [DATA_W-1:0] mem_bytes;
        logic [DATA_W-1:0] fetch_q [PQ_DEPTH];
        int                fetch_head;
        int                fetch_count;
        logic [DATA_W-1:0] exec_q [XQ_DEPTH];
        int                exec_head;
        int                exec_count;
        logic [ERR_W-1:0]  err_state;
        step_result_t      expected_steps [$];
        int                failures;

        function new();
            start_addr = '0;
            mem_bytes  = MEM_SIZE_RESET;
            failures   = 0;
            restart_all();
        endfunction

        function logic [ERR_W-1:0] addr_fault(logic [DATA_W-1:0] pc);
            if (pc >= mem_bytes) return ERR_OOM;
            if (pc[1:0] != 2'b00) return ERR_ALIGN;
            return ERR_NONE;
        endfunction

        function void restart_at(logic [DATA_W-1:0] pc);
            fetch_head  = 0;
            fetch_q[0]  = pc;
            fetch_count = 1;
        endfunction

        function void restart_all();
            restart_at(start_addr);
            exec_head  = 0;
            exec_count = 0;
            err_state  = addr_fault(start_addr);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == CFG_START_PC) start_addr = data;
            else if (idx == CFG_MEM_SIZE) mem_bytes = data;
            else return;
            restart_all();
        endfunction

        function logic [DATA_W-1:0] tail_addr();
            if (fetch_count == 0) return '0;
            return fetch_q[(fetch_head + fetch_count - 1) % PQ_DEPTH];
        endfunction

        function logic [DATA_W-1:0] exec_front();
            return exec_q[exec_head];
        endfunction

        // static prediction: backward branches taken, jumps followed
        function logic [DATA_W-1:0] next_fetch(logic [DATA_W-1:0] pc, logic [31:0] w,
                                               logic [DATA_W-1:0] rs1);
            logic [DATA_W-1:0] off;
            logic [DATA_W-1:0] dest;
            case (w[6:0])
                OP_BRANCH: begin
                    off  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    dest = pc + off;
                    if (w[31] && dest[1:0] == 2'b00) return dest;
                    return pc + 32'(INSTR_BYTES);
                end
                OP_JALR: begin
                    dest    = rs1 + {{20{w[31]}}, w[31:20]};
                    dest[0] = 1'b0;
                    return dest;
                end
                OP_JAL: begin
                    off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                    return pc + off;
                end
                default: return pc + 32'(INSTR_BYTES);
            endcase
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        // accepted request: advance the shadow state and queue its result
        function void note_request(logic [REQ_W-1:0] req, logic [31:0] w,
                                   logic [DATA_W-1:0] rs1, logic [DATA_W-1:0] act);
            step_result_t      r;
            logic [DATA_W-1:0] nxt;
            logic [ERR_W-1:0]  e;
            r = '0;
            if (err_state == ERR_NONE) begin
                case (req)
                    REQ_FILL: begin
                        if (fetch_count == 0) begin
                            err_state = ERR_QEMPTY;
                        end else if (fetch_count < PQ_DEPTH) begin
                            nxt = next_fetch(tail_addr(), w, rs1);
                            e   = addr_fault(nxt);
                            if (e != ERR_NONE) begin
                                err_state = e;
                            end else begin
                                fetch_q[(fetch_head + fetch_count) % PQ_DEPTH] = nxt;
                                fetch_count++;
                            end
                        end
                    end
                    REQ_POP: begin
                        if (fetch_count == 0) begin
                            err_state = ERR_QEMPTY;
                        end else begin
                            r.pc_out   = fetch_q[fetch_head];
                            r.pc_valid = 1'b1;
                            fetch_head = (fetch_head + 1) % PQ_DEPTH;
                            fetch_count--;
                            if (fetch_count == 0) begin
                                err_state = ERR_QEMPTY;
                            end else begin
                                // oldest executing entry falls out when full
                                if (exec_count >= XQ_DEPTH) begin
                                    exec_head = (exec_head + 1) % XQ_DEPTH;
                                    exec_count--;
                                end
                                exec_q[(exec_head + exec_count) % XQ_DEPTH] = fetch_q[fetch_head];
                                exec_count++;
                            end
                        end
                    end
                    REQ_CHECK: begin
                        if (exec_count == 0) begin
                            err_state = ERR_XEMPTY;
                        end else begin
                            nxt       = exec_q[exec_head];
                            exec_head = (exec_head + 1) % XQ_DEPTH;
                            exec_count--;
                            if (nxt == act) begin
                                r.correct = 1'b1;
                            end else begin
                                restart_at(act);
                                err_state = addr_fault(act);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.tail  = tail_addr();
            r.count = COUNT_OUT_W'(fetch_count);
            r.err   = err_state;
            expected_steps.push_back(r);
        endfunction

        // compare one strobed result with the oldest expectation
        function void check_result(step_result_t got);
            step_result_t want;
            if (expected_steps.size() == 0) begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                    $display("result with nothing expected: pc_out=%h valid=%b ok=%b tail=%h",
                             got.pc_out, got.pc_valid, got.correct, got.tail);
                return;
            end
            want = expected_steps.pop_front();
            if (got.pc_out !== want.pc_out || got.pc_valid !== want.pc_valid ||
                got.correct !== want.correct || got.tail !== want.tail ||
                got.count !== want.count || got.err !== want.err) begin
                failures++;
                if (failures <= SHOWN_ERRORS) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected pc_out=%h valid=%b ok=%b tail=%h count=%0d err=%0d",
                             want.pc_out, want.pc_valid, want.correct, want.tail,
                             want.count, want.err);
                    $display("  actual   pc_out=%h valid=%b ok=%b tail=%h count=%0d err=%0d",
                             got.pc_out, got.pc_valid, got.correct, got.tail,
                             got.count, got.err);
                end
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [REQ_W-1:0]       i_req_type;
    logic [DATA_W-1:0]      i_instr_word;
    logic [DATA_W-1:0]      i_rs1_value;
    logic [DATA_W-1:0]      i_actual_pc;
    logic                   o_done;
    logic [DATA_W-1:0]      o_pc_out;
    logic                   o_pc_valid;
    logic                   o_prediction_correct;
    logic [DATA_W-1:0]      o_tail_pc;
    logic [COUNT_OUT_W-1:0] o_queue_count;
    logic [ERR_W-1:0]       o_error_code;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [DATA_W-1:0]      i_cfg_data;

    next_pc_tracker tracker;
    bit             steady_run;
    int             stall_cycles = 0;

    static_next_pc_predictor_queue #(
        .ADDR_WIDTH  (DATA_W),
        .QUEUE_DEPTH (PQ_DEPTH)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_req_type           (i_req_type),
        .i_instr_word         (i_instr_word),
        .i_rs1_value          (i_rs1_value),
        .i_actual_pc          (i_actual_pc),
        .o_done               (o_done),
        .o_pc_out             (o_pc_out),
        .o_pc_valid           (o_pc_valid),
        .o_prediction_correct (o_prediction_correct),
        .o_tail_pc            (o_tail_pc),
        .o_queue_count        (o_queue_count),
        .o_error_code         (o_error_code),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_result('{pc_out: o_pc_out, pc_valid: o_pc_valid,
                                   correct: o_prediction_correct, tail: o_tail_pc,
                                   count: o_queue_count, err: o_error_code});
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // instruction encoders with random filler in the unused bits
    function automatic logic [31:0] enc_branch(logic [12:0] off);
        logic [31:0] w;
        w        = $urandom();
        w[31]    = off[12];
        w[30:25] = off[10:5];
        w[11:8]  = off[4:1];
        w[7]     = off[11];
        w[6:0]   = OP_BRANCH;
        return w;
    endfunction

    function automatic logic [31:0] enc_jal(logic [20:0] off);
        logic [31:0] w;
        w        = $urandom();
        w[31]    = off[20];
        w[30:21] = off[10:1];
        w[20]    = off[11];
        w[19:12] = off[19:12];
        w[6:0]   = OP_JAL;
        return w;
    endfunction

    function automatic logic [31:0] enc_itype(logic [6:0] op, logic [11:0] imm);
        logic [31:0] w;
        w        = $urandom();
        w[31:20] = imm;
        w[6:0]   = op;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] aligned_addr(logic [DATA_W-1:0] mem);
        logic [DATA_W-1:0] lim;
        lim = (mem >= 4) ? mem / 4 - 1 : '0;
        return $urandom_range(0, lim) * 4;
    endfunction

    function automatic logic [REQ_W-1:0] REQ_TYPE_RAND();
        return REQ_W'($urandom_range(0, 3));
    endfunction

    // one request transaction, with random idle cycles ahead of it outside a steady run
    task automatic issue_request(logic [REQ_W-1:0] req, logic [31:0] w,
                                 logic [DATA_W-1:0] rs1, logic [DATA_W-1:0] act);
        @(negedge i_clk);
        while (!steady_run && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_instr_word <= w;
        i_rs1_value  <= rs1;
        i_actual_pc  <= act;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_request(req, w, rs1, act);
    endtask

    // drop start and let every outstanding result come back
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // fill word whose prediction stays inside memory
    task automatic pick_fill(output logic [31:0] w, output logic [DATA_W-1:0] rs1);
        logic [DATA_W-1:0] here;
        logic [12:0]       boff;
        int                tries;
        int                lim;
        here = tracker.tail_addr();
        for (tries = 0; tries < 6; tries++) begin
            rs1 = $urandom();
            case ($urandom_range(0, 3))
                0: begin
                    w = $urandom();
                    if (w[6:0] == OP_BRANCH || w[6:0] == OP_JAL || w[6:0] == OP_JALR)
                        w[6:0] = OP_IMM;
                end
                1: begin
                    boff     = 13'($urandom());
                    boff[12] = ($urandom_range(0, 9) < 7);
                    if ($urandom_range(0, 1)) boff[1] = 1'b0;
                    w = enc_branch(boff);
                end
                2: begin
                    if ($urandom_range(0, 3) != 0)
                        w = enc_itype(OP_JALR, 12'($urandom_range(0, 127) * 4 - 256));
                    else
                        w = enc_itype(OP_JALR, 12'($urandom()));
                    if ($urandom_range(0, 1)) rs1 = aligned_addr(tracker.mem_bytes);
                end
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        w = enc_jal(21'(($urandom_range(0, 2048) - 1024) * 4));
                    else
                        w = enc_jal(21'($urandom()));
                end
            endcase
            if (tracker.addr_fault(tracker.next_fetch(here, w, rs1)) == ERR_NONE) return;
        end
        // short backward jump always lands on a legal pc
        lim = (here / 4 > 1000) ? 1000 : int'(here / 4);
        w   = enc_jal(21'(-4 * $urandom_range(0, lim)));
    endtask

    task automatic run_directed();
        // prediction kinds from pc 0 until the queue is full
        issue_request(REQ_FILL, enc_itype(OP_IMM, 12'h005), $urandom(), $urandom());
        issue_request(REQ_FILL, enc_jal(21'd8), $urandom(), $urandom());
        issue_request(REQ_FILL, enc_branch(13'h1FF8), $urandom(), $urandom()); // back, taken
        issue_request(REQ_FILL, enc_branch(13'd16), $urandom(), $urandom());   // forward
        issue_request(REQ_FILL, enc_branch(13'h1FFA), $urandom(), $urandom()); // back, misaligned
        issue_request(REQ_FILL, enc_itype(OP_JALR, 12'h021), 32'h100, $urandom());
        issue_request(REQ_FILL, enc_itype(OP_REG, 12'h000), $urandom(), $urandom());
        issue_request(REQ_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // full queue
        issue_request(REQ_NOP, $urandom(), $urandom(), $urandom());
        // pops, a correct check, executing queue overflow, then a redirect
        issue_request(REQ_POP, $urandom(), $urandom(), $urandom());
        issue_request(REQ_CHECK, $urandom(), $urandom(), tracker.exec_front());
        repeat (4) issue_request(REQ_POP, $urandom(), $urandom(), $urandom());
        issue_request(REQ_CHECK, $urandom(), $urandom(), 32'h200);
        issue_request(REQ_CHECK, $urandom(), $urandom(), tracker.exec_front());
        // pop that empties the queue, then an ignored fill
        issue_request(REQ_POP, $urandom(), $urandom(), $urandom());
        issue_request(REQ_FILL, 32'h0, 32'h0, 32'h0);
        write_register(CFG_UNUSED, $urandom());
        // prediction beyond memory
        write_register(CFG_MEM_SIZE, 32'h100);
        issue_request(REQ_FILL, enc_jal(21'h200), $urandom(), $urandom());
        // misaligned jalr target
        write_register(CFG_MEM_SIZE, MEM_SIZE_RESET);
        issue_request(REQ_FILL, enc_itype(OP_JALR, 12'h000), 32'h2, $urandom());
        // check with nothing executing
        write_register(CFG_START_PC, 32'h40);
        issue_request(REQ_CHECK, $urandom(), $urandom(), $urandom());
        // redirect out of memory, then misaligned redirect
        write_register(CFG_START_PC, 32'h0);
        issue_request(REQ_FILL, enc_itype(OP_IMM, 12'h000), $urandom(), $urandom());
        issue_request(REQ_POP, $urandom(), $urandom(), $urandom());
        issue_request(REQ_CHECK, $urandom(), $urandom(), 32'hFFFF_FFF0);
        write_register(CFG_START_PC, 32'h0);
        issue_request(REQ_FILL, enc_itype(OP_IMM, 12'h000), $urandom(), $urandom());
        issue_request(REQ_POP, $urandom(), $urandom(), $urandom());
        issue_request(REQ_CHECK, $urandom(), $urandom(), 32'h102);
        // bad start pc faults at restart
        write_register(CFG_START_PC, 32'h3);
        issue_request(REQ_POP, $urandom(), $urandom(), $urandom());
        // top of a full address space wraps to zero
        write_register(CFG_MEM_SIZE, 32'hFFFF_FFFF);
        write_register(CFG_START_PC, 32'hFFFF_FFFC);
        issue_request(REQ_FILL, enc_itype(OP_IMM, 12'h000), $urandom(), $urandom());
    endtask

    task automatic pick_settings();
        logic [DATA_W-1:0] mem;
        logic [DATA_W-1:0] pc;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 45)      mem = MEM_SIZE_RESET;
        else if (r < 75) mem = $urandom_range(16, 4096);
        else if (r < 85) mem = 32'hFFFF_FFFF;
        else if (r < 93) mem = $urandom();
        else             mem = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 70)      pc = aligned_addr(mem);
        else if (r < 80) pc = '0;
        else if (r < 88) pc = (mem & ~32'h3) - 32'd4;
        else if (r < 95) pc = $urandom();
        else             pc = 32'hFFFF_FFFF;
        if ($urandom_range(0, 1)) begin
            write_register(CFG_MEM_SIZE, mem);
            write_register(CFG_START_PC, pc);
        end else begin
            write_register(CFG_START_PC, pc);
            write_register(CFG_MEM_SIZE, mem);
        end
    endtask

    // phases of mostly well-formed fetch traffic, each after a fresh setting
    task automatic run_random();
        logic [REQ_W-1:0]  req;
        logic [31:0]       w;
        logic [DATA_W-1:0] rs1;
        logic [DATA_W-1:0] act;
        int                counted;
        int                phase_len;
        int                r;
        bit                live;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick_settings();
            phase_len = $urandom_range(10, 80);
            while (phase_len > 0 && counted < RANDOM_ITEMS) begin
                if (tracker.err_state != ERR_NONE) begin
                    repeat ($urandom_range(1, 3))
                        issue_request(REQ_TYPE_RAND(), $urandom(), $urandom(), $urandom());
                    break;
                end
                w   = $urandom();
                rs1 = $urandom();
                act = $urandom();
                r   = $urandom_range(0, 99);
                if (r < 10) begin
                    req = REQ_TYPE_RAND();
                end else if (r < 55) begin
                    req = (tracker.fetch_count < PQ_DEPTH || r < 15) ? REQ_FILL : REQ_POP;
                end else if (r < 80) begin
                    req = (tracker.fetch_count >= 2) ? REQ_POP : REQ_FILL;
                end else if (tracker.exec_count > 0) begin
                    req = REQ_CHECK;
                    act = ($urandom_range(0, 4) != 0) ? tracker.exec_front()
                                                      : aligned_addr(tracker.mem_bytes);
                end else begin
                    req = (tracker.fetch_count >= 2) ? REQ_POP : REQ_FILL;
                end
                if (r >= 10 && req == REQ_FILL) pick_fill(w, rs1);
                live = (tracker.err_state == ERR_NONE) && (req != REQ_NOP);
                steady_run = (counted >= 250 && counted < 400);
                issue_request(req, w, rs1, act);
                if (live) counted++;
                phase_len--;
            end
        end
        steady_run = 1'b0;
    endtask

    initial begin
        tracker      = new();
        steady_run   = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = REQ_FILL;
        i_instr_word = '0;
        i_rs1_value  = '0;
        i_actual_pc  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_START_PC;
        i_cfg_data   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        settle();
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
